// ===== hw/rtl/fpa_pkg.sv =====
// fpa_pkg: shared types and constants of the Q24.8 fixed-point ALU
// mode codes, pipeline record and divider sizing
// used by every module of the block, depends on nothing
package fpa_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DATA_W        = 32;

  // radix-2 restoring divider, a few quotient bits per stage
  localparam int DIV_BPS    = 4;
  localparam int DIV_W_MIN  = DATA_W + FRACTION_BITS;
  localparam int DIV_STAGES = (DIV_W_MIN + DIV_BPS - 1) / DIV_BPS;
  localparam int DIV_W      = DIV_STAGES * DIV_BPS;

  // front, divider stages, rounding, output
  localparam int NUM_STAGES = DIV_STAGES + 3;

  localparam logic [2*DATA_W-1:0] MUL_HALF = (2*DATA_W)'(1) << (FRACTION_BITS - 1);

  typedef enum logic [3:0] {
    MODE_ADD     = 4'd0,
    MODE_SUB     = 4'd1,
    MODE_MUL     = 4'd2,
    MODE_DIV     = 4'd3,
    MODE_GT      = 4'd4,
    MODE_LT      = 4'd5,
    MODE_GE      = 4'd6,
    MODE_LE      = 4'd7,
    MODE_EQ      = 4'd8,
    MODE_NE      = 4'd9,
    MODE_MIN     = 4'd10,
    MODE_MAX     = 4'd11,
    MODE_INC     = 4'd12,
    MODE_DEC     = 4'd13,
    MODE_TOINT   = 4'd14,
    MODE_FROMINT = 4'd15
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  neg;
    logic [DATA_W-1:0]     val;
    logic                  cmp;
    logic                  dz;
    logic [DATA_W-1:0]     mb;
    logic [DATA_W-1:0]     rem;
    logic [DIV_W-1:0]      num;
    logic [2*DATA_W-1:0]   prod;
    logic [DATA_W-1:0]     mag;
  } rec_t;

endpackage

// ===== hw/rtl/fpa_front.sv =====
// fpa_front: decode of one operation word into the pipeline record
// simple results, comparisons, magnitudes and divider setup
// depends on fpa_pkg
module fpa_front (
  input  logic [3:0]         mode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output fpa_pkg::rec_t      rec
);

  logic [fpa_pkg::DATA_W-1:0] ma;
  logic [fpa_pkg::DATA_W-1:0] mb;
  fpa_pkg::mode_t             md;

  assign md = fpa_pkg::mode_t'(mode);
  assign ma = operand_a[31] ? (32'd0 - operand_a) : operand_a;
  assign mb = operand_b[31] ? (32'd0 - operand_b) : operand_b;

  always_comb begin
    rec      = '0;
    rec.mode = md;
    rec.neg  = operand_a[31] ^ operand_b[31];
    rec.mb   = mb;
    rec.num  = fpa_pkg::DIV_W'(ma) << fpa_pkg::FRACTION_BITS;
    unique case (md)
      fpa_pkg::MODE_ADD:     rec.val = operand_a + operand_b;
      fpa_pkg::MODE_SUB:     rec.val = operand_a - operand_b;
      fpa_pkg::MODE_MUL:     rec.val = '0;
      fpa_pkg::MODE_DIV:     rec.dz  = (operand_b == 32'sd0);
      fpa_pkg::MODE_GT:      rec.cmp = (operand_a > operand_b);
      fpa_pkg::MODE_LT:      rec.cmp = (operand_a < operand_b);
      fpa_pkg::MODE_GE:      rec.cmp = (operand_a >= operand_b);
      fpa_pkg::MODE_LE:      rec.cmp = (operand_a <= operand_b);
      fpa_pkg::MODE_EQ:      rec.cmp = (operand_a == operand_b);
      fpa_pkg::MODE_NE:      rec.cmp = (operand_a != operand_b);
      fpa_pkg::MODE_MIN:     rec.val = (operand_a < operand_b) ? operand_a : operand_b;
      fpa_pkg::MODE_MAX:     rec.val = (operand_a > operand_b) ? operand_a : operand_b;
      fpa_pkg::MODE_INC:     rec.val = operand_a + 32'sd1;
      fpa_pkg::MODE_DEC:     rec.val = operand_a - 32'sd1;
      fpa_pkg::MODE_TOINT:   rec.val = operand_a >>> fpa_pkg::FRACTION_BITS;
      fpa_pkg::MODE_FROMINT: rec.val = operand_a << fpa_pkg::FRACTION_BITS;
    endcase
  end

endmodule

// ===== hw/rtl/fpa_div_step.sv =====
// fpa_div_step: a few restoring division steps of the divider pipeline
// shifts quotient bits into the low end of the dividend word
// depends on fpa_pkg
module fpa_div_step (
  input  logic [fpa_pkg::DATA_W-1:0] rem_i,
  input  logic [fpa_pkg::DIV_W-1:0]  num_i,
  input  logic [fpa_pkg::DATA_W-1:0] divisor,
  output logic [fpa_pkg::DATA_W-1:0] rem_o,
  output logic [fpa_pkg::DIV_W-1:0]  num_o
);

  always_comb begin
    logic [fpa_pkg::DATA_W-1:0] r;
    logic [fpa_pkg::DIV_W-1:0]  n;
    logic [fpa_pkg::DATA_W:0]   t;
    r = rem_i;
    n = num_i;
    for (int j = 0; j < fpa_pkg::DIV_BPS; j++) begin
      t = {r, n[fpa_pkg::DIV_W-1]};
      n = {n[fpa_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        n[0] = 1'b1;
      end
      // remainder stays below the divisor, so it fits the data width
      r = t[fpa_pkg::DATA_W-1:0];
    end
    rem_o = r;
    num_o = n;
  end

endmodule

// ===== hw/rtl/fixed_point_alu_q24_8.sv =====
// Q24.8 fixed-point ALU, top level: decode, multiplier, pipelined divider,
// rounding and output stages; depends on fpa_pkg, fpa_front, fpa_div_step
//
// Input channel (in_valid/in_stall) takes one operation word: mode and two
// raw Q24.8 operands. Output channel (out_valid/out_stall) returns value,
// compare_true and divide_by_zero for each word, in order.
// Every mode goes through the same pipeline of NUM_STAGES registers:
// one decode stage, DIV_STAGES divider stages (DIV_BPS quotient bits each,
// 10 stages for 8 fraction bits), one rounding stage and the output
// register. One word is accepted every cycle while in_stall is low; the
// divider stage depth sets the latency. Each stage moves on when it is
// empty or the stage after it moves, so a stalled receiver holds the
// output word and the pipeline keeps filling its empty stages; in_stall
// rises only when every stage holds a word. Reset (rst_n low,
// synchronous) empties all stages; the operation itself keeps no state
// between words.
module fixed_point_alu_q24_8 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic               out_compare_true,
  output logic               out_divide_by_zero
);

  localparam int NS      = fpa_pkg::NUM_STAGES;
  localparam int DS      = fpa_pkg::DIV_STAGES;
  localparam int RND_IDX = DS + 1;
  localparam int OUT_IDX = DS + 2;
  localparam int FB      = fpa_pkg::FRACTION_BITS;
  localparam int DW      = fpa_pkg::DATA_W;

  fpa_pkg::rec_t st_r   [NS];
  fpa_pkg::rec_t st_nxt [1:NS-1];
  fpa_pkg::rec_t front_rec;
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  logic [DW-1:0]            step_rem [1:DS];
  logic [fpa_pkg::DIV_W-1:0] step_num [1:DS];

  fpa_front u_front (
    .mode      (in_mode),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .rec       (front_rec)
  );

  // a stage can load when it is empty or its word moves on
  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  for (genvar k = 1; k <= DS; k++) begin : g_div
    fpa_div_step u_step (
      .rem_i   (st_r[k-1].rem),
      .num_i   (st_r[k-1].num),
      .divisor (st_r[k-1].mb),
      .rem_o   (step_rem[k]),
      .num_o   (step_num[k])
    );

    if (k == 1) begin : g_mul
      // multiplier shares the first divider stage; magnitude from the dividend word
      always_comb begin
        st_nxt[k]      = st_r[k-1];
        st_nxt[k].rem  = step_rem[k];
        st_nxt[k].num  = step_num[k];
        st_nxt[k].prod = {{DW{1'b0}}, st_r[k-1].num[FB +: DW]} * {{DW{1'b0}}, st_r[k-1].mb};
      end
    end else begin : g_plain
      always_comb begin
        st_nxt[k]     = st_r[k-1];
        st_nxt[k].rem = step_rem[k];
        st_nxt[k].num = step_num[k];
      end
    end
  end

  // rounding: half away from zero on magnitudes
  always_comb begin
    logic [2*DW-1:0]           psum;
    logic [fpa_pkg::DIV_W-1:0] qsum;
    logic                      rbit;
    psum = st_r[RND_IDX-1].prod + fpa_pkg::MUL_HALF;
    rbit = ({st_r[RND_IDX-1].rem, 1'b0} >= {1'b0, st_r[RND_IDX-1].mb});
    qsum = st_r[RND_IDX-1].num + fpa_pkg::DIV_W'(rbit);
    st_nxt[RND_IDX] = st_r[RND_IDX-1];
    if (st_r[RND_IDX-1].mode == fpa_pkg::MODE_MUL) begin
      st_nxt[RND_IDX].mag = psum[FB +: DW];
    end else begin
      st_nxt[RND_IDX].mag = qsum[DW-1:0];
    end
  end

  // output: apply sign to mul/div, zero on divide by zero, wrap to 32 bits
  always_comb begin
    st_nxt[OUT_IDX] = st_r[OUT_IDX-1];
    priority if (st_r[OUT_IDX-1].mode == fpa_pkg::MODE_DIV && st_r[OUT_IDX-1].dz) begin
      st_nxt[OUT_IDX].val = '0;
    end else if (st_r[OUT_IDX-1].mode == fpa_pkg::MODE_MUL ||
                 st_r[OUT_IDX-1].mode == fpa_pkg::MODE_DIV) begin
      st_nxt[OUT_IDX].val = st_r[OUT_IDX-1].neg ? (32'd0 - st_r[OUT_IDX-1].mag)
                                                : st_r[OUT_IDX-1].mag;
    end else begin
      st_nxt[OUT_IDX].val = st_r[OUT_IDX-1].val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_r[0] <= front_rec;
    end
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_valid          = vld_r[NS-1];
  assign out_value          = st_r[NS-1].val;
  assign out_compare_true   = st_r[NS-1].cmp;
  assign out_divide_by_zero = st_r[NS-1].dz;

  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_value == 32'sd0)
    else $error("divide by zero word carries a nonzero value");

  a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_compare_true && out_divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled while the pipeline has an empty stage");

endmodule
